// ===== sv/tos_pkg.sv =====
package tos_pkg;

    localparam int MACH_FRAC_BITS_DEF = 16;

    localparam int VEL_W   = 32;
    localparam int TEMP_W  = 24;
    localparam int PRES_W  = 36;
    localparam int AREA_W  = 32;
    localparam int MACH_W  = 24;
    localparam int GAMMA_W = 19;
    localparam int GASR_W  = 24;
    localparam int ASUM_W  = 48;
    localparam int SUM_W   = 64;

    localparam int DIV_NW = 128;
    localparam int DIV_DW = 68;

    localparam int QDEPTH = 2;

    localparam int IN_TDATA_W  = 312;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 64;

    localparam logic [PRES_W-1:0]  BACK_PRESSURE_RST = 36'd1621200;
    localparam logic [GAMMA_W-1:0] GAMMA_RST         = 19'd91750;
    localparam logic [GASR_W-1:0]  GASR_RST          = 24'd256;

    localparam logic [GAMMA_W:0]   GAMMA_ONE = 20'd65536;
    localparam logic [MACH_W-1:0]  MACH_MAX  = {MACH_W{1'b1}};
    localparam logic [PRES_W-1:0]  PRES_MAX  = {PRES_W{1'b1}};

    typedef enum logic [1:0] {
        REG_BACK_PRESSURE,
        REG_HEAT_RATIO,
        REG_GAS_CONST,
        REG_SUPERSONIC
    } cfg_reg_t;

    typedef struct packed {
        logic [PRES_W-1:0]  back_pressure;
        logic [GAMMA_W-1:0] gamma;
        logic [GASR_W-1:0]  gas_r;
        logic               supersonic;
    } cfg_t;

    typedef struct packed {
        logic                    mode;
        logic                    last;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vz;
        logic [TEMP_W-1:0]       temp;
        logic [PRES_W-1:0]       pres;
        logic [AREA_W-1:0]       area;
    } face_item_t;

    typedef struct packed {
        logic              frac;
        logic [MACH_W-1:0] metric;
        logic [PRES_W-1:0] shock;
        logic              invalid;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_GR,
        ST_DT,
        ST_DCHK,
        ST_DWAIT,
        ST_SQRT,
        ST_ACC,
        ST_SUM,
        ST_FIN,
        ST_MDIV,
        ST_PDIV,
        ST_SQM,
        ST_GAM,
        ST_XCALC,
        ST_PMUL,
        ST_SDIV,
        ST_SWAIT,
        ST_OUT
    } back_state_t;

endpackage

// ===== sv/transonic_outlet_shock_selector.sv =====
// Channel   Direction  Signals                           Content
// s_*       in         s_tvalid s_tready s_tdata s_tlast one outlet face per item
// m_*       out        m_tvalid m_tready m_tdata m_tuser one decision per patch
// APB       in/out     psel penable pwrite paddr ...     four registers, 8-byte stride
//
// The back end works on one face at a time; a last face in supersonic mode also
// computes the patch averages and the shock pressure. All divides share one divider with a 128-bit quotient.
// The front register and a two-item queue take new faces while the back end works.
// rst_n clears all control state and the patch sums asynchronously.
// The result register holds a decision while m_tready is low and the back end waits.
module transonic_outlet_shock_selector
#(
    parameter int MACH_FRAC_BITS = tos_pkg::MACH_FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // face_vel_x, face_vel_y, face_vel_z, cell_vel_x, cell_vel_y, cell_vel_z,
    // face_temperature, cell_temperature, face_pressure, face_area, zero pad
    input  logic [tos_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // value_fraction, mach_metric, shock_pressure, zero pad
    output logic [tos_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // invalid
    output logic [0:0]                           m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tos_pkg::CFG_AW-1:0]           paddr,
    input  logic [tos_pkg::CFG_DW-1:0]           pwdata,
    output logic [tos_pkg::CFG_DW-1:0]           prdata,
    output logic                                 pready
);

    tos_pkg::cfg_t        cfg_reg, cfg_next;
    tos_pkg::cfg_reg_t    sel;
    tos_pkg::face_item_t  front_item;
    tos_pkg::face_item_t  q_item;
    tos_pkg::result_t     result;
    logic                 front_valid;
    logic                 q_ready;
    logic                 q_valid;
    logic                 q_pop;
    logic                 wr_en;

    assign pready = 1'b1;
    assign sel    = tos_pkg::cfg_reg_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                tos_pkg::REG_BACK_PRESSURE: cfg_next.back_pressure = pwdata[35:0];
                tos_pkg::REG_HEAT_RATIO:    cfg_next.gamma         = pwdata[18:0];
                tos_pkg::REG_GAS_CONST:     cfg_next.gas_r         = pwdata[23:0];
                tos_pkg::REG_SUPERSONIC:    cfg_next.supersonic    = pwdata[0];
                default:                    cfg_next               = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            tos_pkg::REG_BACK_PRESSURE: prdata = {28'd0, cfg_reg.back_pressure};
            tos_pkg::REG_HEAT_RATIO:    prdata = {45'd0, cfg_reg.gamma};
            tos_pkg::REG_GAS_CONST:     prdata = {40'd0, cfg_reg.gas_r};
            tos_pkg::REG_SUPERSONIC:    prdata = {63'd0, cfg_reg.supersonic};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.back_pressure <= tos_pkg::BACK_PRESSURE_RST;
            cfg_reg.gamma         <= tos_pkg::GAMMA_RST;
            cfg_reg.gas_r         <= tos_pkg::GASR_RST;
            cfg_reg.supersonic    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tos_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .supersonic (cfg_reg.supersonic),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (front_valid),
        .item_ready (q_ready),
        .item       (front_item)
    );

    tos_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (q_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_item  (q_item)
    );

    tos_back #(.MACH_FRAC_BITS(MACH_FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = {3'd0, result.shock, result.metric, result.frac};
    assign m_tuser = result.invalid;

endmodule

// ===== sv/tos_div.sv =====
module tos_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tos_pkg::DIV_NW-1:0]     num,
    input  logic [tos_pkg::DIV_DW-1:0]     den,
    output logic                           done,
    output logic [tos_pkg::DIV_NW-1:0]     quo
);

    localparam int CNT_W = $clog2(tos_pkg::DIV_NW);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [tos_pkg::DIV_DW-1:0]    rem_reg, rem_next;
    logic [tos_pkg::DIV_NW-1:0]    quo_reg, quo_next;
    logic [tos_pkg::DIV_DW-1:0]    den_reg, den_next;
    logic [tos_pkg::DIV_DW:0]      rem_sh;
    logic [tos_pkg::DIV_DW:0]      diff;
    logic                          ge;

    assign rem_sh = {rem_reg, quo_reg[tos_pkg::DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(tos_pkg::DIV_NW - 1);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[tos_pkg::DIV_DW-1:0] : rem_sh[tos_pkg::DIV_DW-1:0];
            quo_next = {quo_reg[tos_pkg::DIV_NW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/tos_front.sv =====
module tos_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                supersonic,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tos_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                item_valid,
    input  logic                                item_ready,
    output tos_pkg::face_item_t                 item
);

    logic                 valid_reg, valid_next;
    tos_pkg::face_item_t  item_reg, item_next;
    logic                 accept;

    assign s_tready = !valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    // The mode in force when a face arrives picks the face or the cell side.
    always_comb
    begin
        item_next = item_reg;
        valid_next = valid_reg && !item_ready;
        if (accept)
        begin
            valid_next     = 1'b1;
            item_next.mode = supersonic;
            item_next.last = s_tlast;
            if (supersonic)
            begin
                item_next.vx   = s_tdata[31:0];
                item_next.vy   = s_tdata[63:32];
                item_next.vz   = s_tdata[95:64];
                item_next.temp = s_tdata[215:192];
            end
            else
            begin
                item_next.vx   = s_tdata[127:96];
                item_next.vy   = s_tdata[159:128];
                item_next.vz   = s_tdata[191:160];
                item_next.temp = s_tdata[239:216];
            end
            item_next.pres = s_tdata[275:240];
            item_next.area = s_tdata[307:276];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/tos_queue.sv =====
module tos_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tos_pkg::face_item_t  in_item,
    output logic                 out_valid,
    input  logic                 pop,
    output tos_pkg::face_item_t  out_item
);

    localparam int PTR_W = $clog2(tos_pkg::QDEPTH);
    localparam int CNT_W = $clog2(tos_pkg::QDEPTH + 1);

    tos_pkg::face_item_t  mem_reg [tos_pkg::QDEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push;
    logic                 take;

    assign in_ready  = count_reg != CNT_W'(tos_pkg::QDEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign take      = pop && out_valid;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tos_pkg::QDEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tos_pkg::QDEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !take)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (take && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== sv/tos_back.sv =====
module tos_back
#(
    parameter int MACH_FRAC_BITS = tos_pkg::MACH_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tos_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    input  tos_pkg::face_item_t  q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tos_pkg::result_t     result
);

    localparam int SH2  = 2 * MACH_FRAC_BITS;
    localparam int NSH  = 16 + SH2;
    localparam int X_W  = 72;
    localparam int PR_W = 108;

    tos_pkg::back_state_t  state_reg, state_next;
    tos_pkg::face_item_t   item_reg, item_next;
    logic [63:0]           u2_reg, u2_next;
    logic [1:0]            idx_reg, idx_next;
    logic [42:0]           gr_reg, gr_next;
    logic [66:0]           d_reg, d_next;
    logic [47:0]           rad_reg, rad_next;
    logic [47:0]           root_reg, root_next;
    logic [47:0]           bit_reg, bit_next;
    logic [23:0]           mach_reg, mach_next;
    logic [55:0]           ma_reg, ma_next;
    logic [67:0]           pa_reg, pa_next;
    logic [47:0]           asum_reg, asum_next;
    logic [63:0]           mas_reg, mas_next;
    logic [63:0]           pas_reg, pas_next;
    logic [23:0]           max_reg, max_next;
    logic                  bad_reg, bad_next;
    logic [23:0]           mavg_reg, mavg_next;
    logic [35:0]           pavg_reg, pavg_next;
    logic [47:0]           msq_reg, msq_next;
    logic [67:0]           a_reg, a_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [55:0]           gpb_reg, gpb_next;
    logic [PR_W-1:0]       prod_reg, prod_next;
    logic [1:0]            chunk_reg, chunk_next;
    tos_pkg::result_t      res_reg, res_next;
    tos_pkg::result_t      out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  div_start;
    logic [127:0]          div_num;
    logic [67:0]           div_den;
    logic                  div_done;
    logic [127:0]          div_quo;

    logic [31:0]           comp;
    logic [31:0]           mag;
    logic [63:0]           sq;
    logic [48:0]           root_try;
    logic [55:0]           ma_prod;
    logic [67:0]           pa_prod;
    logic [48:0]           asum_add;
    logic [64:0]           mas_add;
    logic [64:0]           pas_add;
    logic [19:0]           g20;
    logic [19:0]           gp1;
    logic [47:0]           msq_prod;
    logic [66:0]           ga_prod;
    logic [X_W-1:0]        a_ext;
    logic [X_W-1:0]        b_val;
    logic [X_W-1:0]        add_val;
    logic [55:0]           gpb_prod;
    logic [23:0]           x_chunk;
    logic [59:0]           part;
    logic [PR_W-1:0]       part_sh;
    logic [111:0]          bp_lim;

    tos_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        case (idx_reg)
            2'd0:    comp = item_reg.vx;
            2'd1:    comp = item_reg.vy;
            default: comp = item_reg.vz;
        endcase
    end

    assign mag      = comp[31] ? (~comp + 32'd1) : comp;
    assign sq       = mag * mag;
    assign root_try = {1'b0, root_reg} + {1'b0, bit_reg};
    assign ma_prod  = mach_reg * item_reg.area;
    assign pa_prod  = item_reg.pres * item_reg.area;
    assign asum_add = {1'b0, asum_reg} + {17'd0, item_reg.area};
    assign mas_add  = {1'b0, mas_reg} + {9'd0, ma_reg};
    assign pas_add  = {1'b0, pas_reg} + {1'b0, pa_reg[63:0]};
    assign g20      = {1'b0, cfg.gamma};
    assign gp1      = g20 + tos_pkg::GAMMA_ONE;
    assign msq_prod = mavg_reg * mavg_reg;
    assign ga_prod  = msq_reg * cfg.gamma;
    assign a_ext    = {{(X_W - 68){1'b0}}, a_reg};
    assign b_val    = {{(X_W - 20){1'b0}}, g20 - tos_pkg::GAMMA_ONE} << SH2;
    assign add_val  = {{(X_W - 20){1'b0}}, tos_pkg::GAMMA_ONE - g20} << SH2;
    assign gpb_prod = gp1 * cfg.back_pressure;
    assign bp_lim   = {56'd0, gpb_reg} << SH2;

    always_comb
    begin
        case (chunk_reg)
            2'd0:    x_chunk = x_reg[23:0];
            2'd1:    x_chunk = x_reg[47:24];
            default: x_chunk = x_reg[71:48];
        endcase
    end

    assign part = x_chunk * pavg_reg;

    always_comb
    begin
        case (chunk_reg)
            2'd0:    part_sh = {48'd0, part};
            2'd1:    part_sh = {24'd0, part, 24'd0};
            default: part_sh = {part, 48'd0};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        u2_next        = u2_reg;
        idx_next       = idx_reg;
        gr_next        = gr_reg;
        d_next         = d_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        mach_next      = mach_reg;
        ma_next        = ma_reg;
        pa_next        = pa_reg;
        asum_next      = asum_reg;
        mas_next       = mas_reg;
        pas_next       = pas_reg;
        max_next       = max_reg;
        bad_next       = bad_reg;
        mavg_next      = mavg_reg;
        pavg_next      = pavg_reg;
        msq_next       = msq_reg;
        a_next         = a_reg;
        x_next         = x_reg;
        gpb_next       = gpb_reg;
        prod_next      = prod_reg;
        chunk_next     = chunk_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_num        = {64'd0, u2_reg} << NSH;
        div_den        = {1'b0, d_reg};

        case (state_reg)
            tos_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    u2_next    = '0;
                    idx_next   = '0;
                    state_next = tos_pkg::ST_SQ;
                end
            end
            tos_pkg::ST_SQ:
            begin
                u2_next  = u2_reg + sq;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    state_next = tos_pkg::ST_GR;
                end
            end
            tos_pkg::ST_GR:
            begin
                gr_next    = cfg.gamma * cfg.gas_r;
                state_next = tos_pkg::ST_DT;
            end
            tos_pkg::ST_DT:
            begin
                d_next     = gr_reg * item_reg.temp;
                state_next = tos_pkg::ST_DCHK;
            end
            tos_pkg::ST_DCHK:
            begin
                if (d_reg == '0)
                begin
                    mach_next  = tos_pkg::MACH_MAX;
                    bad_next   = 1'b1;
                    state_next = tos_pkg::ST_ACC;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = tos_pkg::ST_DWAIT;
                end
            end
            tos_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (div_quo[127:48] != '0)
                    begin
                        mach_next  = tos_pkg::MACH_MAX;
                        state_next = tos_pkg::ST_ACC;
                    end
                    else
                    begin
                        rad_next   = div_quo[47:0];
                        root_next  = '0;
                        bit_next   = 48'd1 << 46;
                        state_next = tos_pkg::ST_SQRT;
                    end
                end
            end
            tos_pkg::ST_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    mach_next  = root_reg[23:0];
                    state_next = tos_pkg::ST_ACC;
                end
                else
                begin
                    if ({1'b0, rad_reg} >= root_try)
                    begin
                        rad_next  = rad_reg - root_try[47:0];
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            tos_pkg::ST_ACC:
            begin
                ma_next    = ma_prod;
                pa_next    = pa_prod;
                state_next = tos_pkg::ST_SUM;
            end
            tos_pkg::ST_SUM:
            begin
                if (item_reg.mode)
                begin
                    asum_next = asum_add[48] ? '1 : asum_add[47:0];
                    mas_next  = mas_add[64] ? '1 : mas_add[63:0];
                    pas_next  = (pa_reg[67:64] != '0 || pas_add[64]) ? '1 : pas_add[63:0];
                end
                else if (mach_reg > max_reg)
                begin
                    max_next = mach_reg;
                end
                state_next = item_reg.last ? tos_pkg::ST_FIN : tos_pkg::ST_IDLE;
            end
            tos_pkg::ST_FIN:
            begin
                res_next.frac    = 1'b1;
                res_next.metric  = '0;
                res_next.shock   = '0;
                res_next.invalid = bad_reg;
                if (!item_reg.mode)
                begin
                    res_next.metric = max_reg;
                    res_next.frac   = !({1'b0, max_reg} > (25'd1 << MACH_FRAC_BITS));
                    state_next      = tos_pkg::ST_OUT;
                end
                else if (asum_reg == '0)
                begin
                    res_next.invalid = 1'b1;
                    state_next       = tos_pkg::ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {64'd0, mas_reg};
                    div_den    = {20'd0, asum_reg};
                    state_next = tos_pkg::ST_MDIV;
                end
            end
            tos_pkg::ST_MDIV:
            begin
                if (div_done)
                begin
                    mavg_next       = (div_quo[127:24] != '0) ? tos_pkg::MACH_MAX
                                    : div_quo[23:0];
                    res_next.metric = mavg_next;
                    div_start       = 1'b1;
                    div_num         = {64'd0, pas_reg};
                    div_den         = {20'd0, asum_reg};
                    state_next      = tos_pkg::ST_PDIV;
                end
            end
            tos_pkg::ST_PDIV:
            begin
                if (div_done)
                begin
                    pavg_next  = (div_quo[127:36] != '0) ? tos_pkg::PRES_MAX
                               : div_quo[35:0];
                    state_next = tos_pkg::ST_SQM;
                end
            end
            tos_pkg::ST_SQM:
            begin
                msq_next   = msq_prod;
                state_next = tos_pkg::ST_GAM;
            end
            tos_pkg::ST_GAM:
            begin
                a_next     = {ga_prod, 1'b0};
                state_next = tos_pkg::ST_XCALC;
            end
            tos_pkg::ST_XCALC:
            begin
                gpb_next   = gpb_prod;
                prod_next  = '0;
                chunk_next = '0;
                state_next = tos_pkg::ST_PMUL;
                if (g20 >= tos_pkg::GAMMA_ONE)
                begin
                    if (a_ext < b_val)
                    begin
                        state_next = tos_pkg::ST_OUT;
                    end
                    else
                    begin
                        x_next = a_ext - b_val;
                    end
                end
                else
                begin
                    x_next = a_ext + add_val;
                end
            end
            tos_pkg::ST_PMUL:
            begin
                prod_next  = prod_reg + part_sh;
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg == 2'd2)
                begin
                    state_next = tos_pkg::ST_SDIV;
                end
            end
            tos_pkg::ST_SDIV:
            begin
                res_next.frac = !({4'd0, prod_reg} > bp_lim);
                div_start     = 1'b1;
                div_num       = {20'd0, prod_reg} >> SH2;
                div_den       = {48'd0, gp1};
                state_next    = tos_pkg::ST_SWAIT;
            end
            tos_pkg::ST_SWAIT:
            begin
                if (div_done)
                begin
                    res_next.shock = (div_quo[127:36] != '0) ? tos_pkg::PRES_MAX
                                   : div_quo[35:0];
                    state_next     = tos_pkg::ST_OUT;
                end
            end
            tos_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    asum_next      = '0;
                    mas_next       = '0;
                    pas_next       = '0;
                    max_next       = '0;
                    bad_next       = 1'b0;
                    state_next     = tos_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tos_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tos_pkg::ST_IDLE;
            asum_reg      <= '0;
            mas_reg       <= '0;
            pas_reg       <= '0;
            max_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            asum_reg      <= asum_next;
            mas_reg       <= mas_next;
            pas_reg       <= pas_next;
            max_reg       <= max_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        u2_reg    <= u2_next;
        idx_reg   <= idx_next;
        gr_reg    <= gr_next;
        d_reg     <= d_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        mach_reg  <= mach_next;
        ma_reg    <= ma_next;
        pa_reg    <= pa_next;
        mavg_reg  <= mavg_next;
        pavg_reg  <= pavg_next;
        msq_reg   <= msq_next;
        a_reg     <= a_next;
        x_reg     <= x_next;
        gpb_reg   <= gpb_next;
        prod_reg  <= prod_next;
        chunk_reg <= chunk_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule
